>>> rtl/core/assert_macros.svh
// Assertion helper macros shared by the RTL files that carry checks.
// No dependencies; included by file name where needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tac assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TAC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tac assertion failed");

`endif

>>> rtl/core/tac_pkg.sv
// Shared types, sizes and helpers for the TTL address cache.
// No dependencies; imported by the cache core.
package tac_pkg;

    localparam int ENTRIES   = 256;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W     = 48;
    localparam int TIME_W    = 32;
    localparam int SLOT_W    = 8;
    localparam int ACT_W     = 2;
    localparam int ENTRY_W   = KEY_W + TIME_W;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;
    localparam int M_PAD_W   = M_TDATA_W - (1 + ACT_W + SLOT_W);

    localparam logic [TIME_W-1:0] TTL_RESET = 32'd300000;

    localparam logic OP_MARK   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOOKUP  = 2'd0,
        ACT_REFRESH = 2'd1,
        ACT_FILL    = 2'd2,
        ACT_REPLACE = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    // now + ttl, clamped at all ones
    function automatic logic [TIME_W-1:0] expiry_sum(input logic [TIME_W-1:0] now_v,
                                                     input logic [TIME_W-1:0] ttl_v);
        logic [TIME_W:0] sum;
        sum = {1'b0, now_v} + {1'b0, ttl_v};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

    // low slot bits of an entry index, zero-extended for small stores
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

>>> rtl/core/tac_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/ttl_address_cache_core.sv
// TTL address cache core: sequencer, valid bits and one shared entry compare unit.
// Depends on tac_pkg, tac_ram and assert_macros.svh.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser opcode, s_tdata key + now
//  m_      | out | m_tvalid/m_tready  | m_tdata hit, action, slot
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data time_to_live
//
// One entry is read and compared per cycle. A mark goes from acceptance through the
// scan, write and result states, and a lookup through scan and result; the scan ends
// at the first matching entry, and a mark that misses, or a lookup that misses, walks
// all ENTRIES. The result state holds while an earlier result still waits on m_tready.
// Reset clears every valid bit at once; no clearing pass. s_tready is high only
// between items; a result waiting on m_tready does not block the next transfer.
`include "assert_macros.svh"

module ttl_address_cache_core
    import tac_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [47:0] address_key, [79:48] now
    input  logic                 s_tuser,   // [0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] hit, [2:1] action, [10:3] slot, rest 0
    input  logic                 cfg_wr_en,
    input  logic [TIME_W-1:0]    cfg_wr_data
);

    state_t                state_reg, state_next;
    logic [TIME_W-1:0]     ttl_reg, ttl_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic                  m_vld_reg, m_vld_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic                  chk_vld_reg, chk_vld_next;

    logic                  op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [TIME_W-1:0]     exp_reg, exp_next;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                  vbit_reg, vbit_next;
    logic                  free_fnd_reg, free_fnd_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  seen_reg, seen_next;
    logic [TIME_W-1:0]     ear_exp_reg, ear_exp_next;
    logic [IDX_W-1:0]      ear_idx_reg, ear_idx_next;
    logic                  res_hit_reg, res_hit_next;
    action_t               res_act_reg, res_act_next;
    logic [IDX_W-1:0]      wr_idx_reg, wr_idx_next;

    logic [IDX_W-1:0]      rd_idx;
    logic                  rd_more;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [KEY_W-1:0]      ent_key;
    logic [TIME_W-1:0]     ent_exp;
    logic                  key_eq;
    logic                  live;
    logic                  ent_match;
    logic                  ent_free;
    logic                  chk_last;

    assign rd_idx   = rd_cnt_reg[IDX_W-1:0];
    assign rd_more  = (rd_cnt_reg < CNT_W'(ENTRIES));
    assign ent_key  = ram_rdata[ENTRY_W-1:TIME_W];
    assign ent_exp  = ram_rdata[TIME_W-1:0];
    assign key_eq   = (ent_key == key_reg);
    assign live     = (ent_exp > now_reg);
    assign ent_match = vbit_reg && key_eq && ((op_reg == OP_MARK) || live);
    assign ent_free  = !vbit_reg || !live;
    assign chk_last  = (chk_idx_reg == IDX_W'(ENTRIES - 1));

    tac_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (aclk),
        .wr_en   (state_reg == ST_WRITE),
        .wr_addr (wr_idx_reg),
        .wr_data ({key_reg, exp_reg}),
        .rd_addr (rd_idx),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        ttl_next      = ttl_reg;
        valid_next    = valid_reg;
        m_vld_next    = m_vld_reg;
        m_data_next   = m_data_reg;
        chk_vld_next  = chk_vld_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        now_next      = now_reg;
        exp_next      = exp_reg;
        rd_cnt_next   = rd_cnt_reg;
        chk_idx_next  = chk_idx_reg;
        vbit_next     = vbit_reg;
        free_fnd_next = free_fnd_reg;
        free_idx_next = free_idx_reg;
        seen_next     = seen_reg;
        ear_exp_next  = ear_exp_reg;
        ear_idx_next  = ear_idx_reg;
        res_hit_next  = res_hit_reg;
        res_act_next  = res_act_reg;
        wr_idx_next   = wr_idx_reg;

        if (cfg_wr_en) begin
            ttl_next = cfg_wr_data;
        end
        if (m_vld_reg && m_tready) begin
            m_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                chk_vld_next = 1'b0;
                if (s_tvalid) begin
                    op_next       = s_tuser;
                    key_next      = s_tdata[KEY_W-1:0];
                    now_next      = s_tdata[KEY_W+TIME_W-1:KEY_W];
                    exp_next      = expiry_sum(s_tdata[KEY_W+TIME_W-1:KEY_W], ttl_reg);
                    rd_cnt_next   = '0;
                    free_fnd_next = 1'b0;
                    seen_next     = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read stage: issue next entry
                rd_cnt_next  = rd_more ? rd_cnt_reg + 1'b1 : rd_cnt_reg;
                chk_vld_next = rd_more;
                chk_idx_next = rd_idx;
                vbit_next    = valid_reg[rd_idx];
                // check stage: entry read last cycle
                if (chk_vld_reg) begin
                    if (ent_match) begin
                        chk_vld_next = 1'b0;
                        res_hit_next = 1'b1;
                        wr_idx_next  = chk_idx_reg;
                        if (op_reg == OP_LOOKUP) begin
                            res_act_next = ACT_LOOKUP;
                            state_next   = ST_RESULT;
                        end else begin
                            res_act_next = ACT_REFRESH;
                            state_next   = ST_WRITE;
                        end
                    end else begin
                        if (ent_free) begin
                            if (!free_fnd_reg) begin
                                free_fnd_next = 1'b1;
                                free_idx_next = chk_idx_reg;
                            end
                        end else if (!seen_reg || ent_exp < ear_exp_reg) begin
                            seen_next    = 1'b1;
                            ear_exp_next = ent_exp;
                            ear_idx_next = chk_idx_reg;
                        end
                        if (chk_last) begin
                            chk_vld_next = 1'b0;
                            res_hit_next = 1'b0;
                            if (op_reg == OP_LOOKUP) begin
                                res_act_next = ACT_LOOKUP;
                                wr_idx_next  = '0;
                                state_next   = ST_RESULT;
                            end else if (free_fnd_reg || ent_free) begin
                                res_act_next = ACT_FILL;
                                wr_idx_next  = free_fnd_reg ? free_idx_reg : chk_idx_reg;
                                state_next   = ST_WRITE;
                            end else begin
                                res_act_next = ACT_REPLACE;
                                wr_idx_next  = (!seen_reg || ent_exp < ear_exp_reg) ?
                                               chk_idx_reg : ear_idx_reg;
                                state_next   = ST_WRITE;
                            end
                        end
                    end
                end
            end
            ST_WRITE: begin
                valid_next[wr_idx_reg] = 1'b1;
                state_next             = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_vld_reg || m_tready) begin
                    m_vld_next  = 1'b1;
                    m_data_next = {{M_PAD_W{1'b0}}, slot_of(wr_idx_reg), res_act_reg,
                                   res_hit_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ttl_reg     <= TTL_RESET;
            valid_reg   <= '0;
            m_vld_reg   <= 1'b0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ttl_reg     <= ttl_next;
            valid_reg   <= valid_next;
            m_vld_reg   <= m_vld_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        now_reg      <= now_next;
        exp_reg      <= exp_next;
        rd_cnt_reg   <= rd_cnt_next;
        chk_idx_reg  <= chk_idx_next;
        vbit_reg     <= vbit_next;
        free_fnd_reg <= free_fnd_next;
        free_idx_reg <= free_idx_next;
        seen_reg     <= seen_next;
        ear_exp_reg  <= ear_exp_next;
        ear_idx_reg  <= ear_idx_next;
        res_hit_reg  <= res_hit_next;
        res_act_reg  <= res_act_next;
        wr_idx_reg   <= wr_idx_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

    // lookup miss reports slot zero
    `TAC_ASSERT_IMPL(a_miss_slot_zero, aclk, aresetn,
        m_tvalid && (m_tdata[2:1] == ACT_LOOKUP) && !m_tdata[0], m_tdata[10:3] == '0)
    // fill and replace never report a hit
    `TAC_ASSERT_IMPL(a_alloc_no_hit, aclk, aresetn,
        m_tvalid && ((m_tdata[2:1] == ACT_FILL) || (m_tdata[2:1] == ACT_REPLACE)),
        !m_tdata[0])
    // written entry is valid afterwards
    `TAC_ASSERT_NEXT(a_write_sets_valid, aclk, aresetn,
        state_reg == ST_WRITE, valid_reg[$past(wr_idx_reg)])
    // check stage only runs while scanning
    `TAC_ASSERT_IMPL(a_check_in_scan, aclk, aresetn,
        chk_vld_reg, state_reg == ST_SCAN)

endmodule

>>> bench/tb_ttl_address_cache_core.sv
// Self-checking bench for ttl_address_cache_core: directed table, then random mark/lookup phases.
// Depends on tac_pkg and the core RTL; a built-in cache predictor supplies expected results.
module tb_ttl_address_cache_core
    import tac_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS = 1170;

    typedef struct packed {
        logic             hit;
        action_t          act;
        logic [SLOT_W-1:0] slot;
    } cache_result_t;

    typedef enum logic [1:0] {
        ROW_TTL,        // write time_to_live from the value column
        ROW_PREDICT,    // checked against the predictor
        ROW_PINNED      // checked against the typed-in result
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] value;   // now, or the new lifetime on ROW_TTL
        logic              hit;
        action_t           act;
        logic [SLOT_W-1:0] slot;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = OP_MARK;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [TIME_W-1:0]    cfg_wr_data = '0;

    // predicted cache contents
    logic                 tbl_valid  [ENTRIES];
    logic [KEY_W-1:0]     tbl_key    [ENTRIES];
    logic [TIME_W-1:0]    tbl_expiry [ENTRIES];
    logic [TIME_W-1:0]    ttl_ms = TTL_RESET;

    cache_result_t        result_queue[$];
    logic [KEY_W-1:0]     known_keys[$];
    logic [TIME_W-1:0]    clock_ms = '0;
    int                   sent_count = 0;
    int                   results_seen = 0;
    int                   error_count = 0;
    int                   send_idle_pct = 35;
    int                   recv_idle_pct = 77;

    row_t directed_rows [24] = '{
        {ROW_PINNED,  OP_LOOKUP, 48'h0,               32'd0,          1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PINNED,  OP_MARK,   48'hFFFF_FFFF_FFFF,  32'd0,          1'b0, ACT_FILL,    8'd0},
        {ROW_PINNED,  OP_LOOKUP, 48'hFFFF_FFFF_FFFF,  32'd0,          1'b1, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_LOOKUP, 48'hFFFF_FFFF_FFFF,  32'd299999,     1'b0, ACT_LOOKUP,  8'd0},
        // expiry equal to now is already dead
        {ROW_PINNED,  OP_LOOKUP, 48'hFFFF_FFFF_FFFF,  32'd300000,     1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_MARK,   48'h0,               32'd1000,       1'b0, ACT_LOOKUP,  8'd0},
        // expired entry with the same key is refreshed, not refilled
        {ROW_PINNED,  OP_MARK,   48'hFFFF_FFFF_FFFF,  32'd400000,     1'b1, ACT_REFRESH, 8'd0},
        {ROW_PREDICT, OP_LOOKUP, 48'h0,               32'd1000,       1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_LOOKUP, 48'h1,               32'd0,          1'b0, ACT_LOOKUP,  8'd0},
        // expiry saturates at all ones
        {ROW_PREDICT, OP_MARK,   48'hAAAA_AAAA_AAAA,  32'hFFFF_FFF0,  1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_LOOKUP, 48'hAAAA_AAAA_AAAA,  32'hFFFF_FFFE,  1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PINNED,  OP_LOOKUP, 48'hAAAA_AAAA_AAAA,  32'hFFFF_FFFF,  1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_MARK,   48'h5555_5555_5555,  32'hFFFF_FFFF,  1'b0, ACT_LOOKUP,  8'd0},
        // zero lifetime: a fresh entry is dead on arrival
        {ROW_TTL,     OP_MARK,   48'h0,               32'd0,          1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_MARK,   48'h0A00_0001_1F90,  32'd5000,       1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PINNED,  OP_LOOKUP, 48'h0A00_0001_1F90,  32'd5000,       1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_MARK,   48'h0A00_0001_1F90,  32'd6000,       1'b0, ACT_LOOKUP,  8'd0},
        {ROW_TTL,     OP_MARK,   48'h0,               32'hFFFF_FFFF,  1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_MARK,   48'hC0A8_0101_0035,  32'd10,         1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_LOOKUP, 48'hC0A8_0101_0035,  32'hFFFF_FFFE,  1'b0, ACT_LOOKUP,  8'd0},
        {ROW_TTL,     OP_MARK,   48'h0,               32'd1,          1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_MARK,   48'hC0A8_0101_0035,  32'd7,          1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_LOOKUP, 48'hC0A8_0101_0035,  32'd7,          1'b0, ACT_LOOKUP,  8'd0},
        {ROW_PREDICT, OP_LOOKUP, 48'hC0A8_0101_0035,  32'd8,          1'b0, ACT_LOOKUP,  8'd0}
    };

    ttl_address_cache_core u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic note_mismatch(input string what);
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
        error_count++;
    endtask

    // Expected outcome of one item; updates the predicted cache contents.
    function automatic cache_result_t cache_predict(input logic op,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [TIME_W-1:0] now);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] new_expiry;
        logic [TIME_W-1:0] oldest;
        int                victim;
        sum = {1'b0, now} + {1'b0, ttl_ms};
        new_expiry = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        if (op == OP_LOOKUP) begin
            for (int i = 0; i < ENTRIES; i++)
                if (tbl_valid[i] && tbl_expiry[i] > now && tbl_key[i] == key)
                    return {1'b1, ACT_LOOKUP, SLOT_W'(i)};
            return {1'b0, ACT_LOOKUP, {SLOT_W{1'b0}}};
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_key[i] == key) begin
                tbl_expiry[i] = new_expiry;
                return {1'b1, ACT_REFRESH, SLOT_W'(i)};
            end
        end
        // entry 0 starts the oldest-entry search; it is used only if no entry is free
        victim = 0;
        oldest = tbl_expiry[0];
        for (int i = 0; i < ENTRIES; i++) begin
            if (!tbl_valid[i] || tbl_expiry[i] <= now) begin
                tbl_valid[i] = 1'b1;
                tbl_key[i] = key;
                tbl_expiry[i] = new_expiry;
                return {1'b0, ACT_FILL, SLOT_W'(i)};
            end
            if (tbl_expiry[i] < oldest) begin
                oldest = tbl_expiry[i];
                victim = i;
            end
        end
        tbl_key[victim] = key;
        tbl_expiry[victim] = new_expiry;
        return {1'b0, ACT_REPLACE, SLOT_W'(victim)};
    endfunction

    task automatic set_ttl(input logic [TIME_W-1:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (result_queue.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        ttl_ms = value;
    endtask

    task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                             input logic [TIME_W-1:0] now, input logic pinned,
                             input cache_result_t pinned_res);
        cache_result_t predicted;
        if (sent_count < TOTAL_ITEMS / 3) begin
            send_idle_pct = 35;
            recv_idle_pct = 77;
        end else if (sent_count < 2 * TOTAL_ITEMS / 3) begin
            send_idle_pct = 77;
            recv_idle_pct = 35;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {now, key};
        do @(posedge aclk); while (!s_tready);
        predicted = cache_predict(op, key, now);
        result_queue.push_back(pinned ? pinned_res : predicted);
        sent_count++;
    endtask

    // Random traffic: a working set of known keys on a moving clock,
    // fresh keys to grow the cache, and optional wild timestamps as noise.
    task automatic run_phase(input logic [TIME_W-1:0] ttl, input int items, input int mark_pct,
                             input int fresh_pct, input int pool_cap, input int step_max,
                             input int wild_pct);
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        int                lo;
        int                fresh;
        set_ttl(ttl);
        repeat (items) begin
            op = ($urandom_range(99) < mark_pct) ? OP_MARK : OP_LOOKUP;
            fresh = (op == OP_MARK) ? fresh_pct : 15;
            lo = (known_keys.size() > pool_cap) ? known_keys.size() - pool_cap : 0;
            if (known_keys.size() == 0 || $urandom_range(99) < fresh) begin
                key = KEY_W'({$urandom, $urandom});
                if (op == OP_MARK)
                    known_keys.push_back(key);
            end else begin
                key = known_keys[$urandom_range(known_keys.size() - 1, lo)];
            end
            clock_ms += TIME_W'($urandom_range(step_max, 0));
            now = ($urandom_range(99) < wild_pct) ? $urandom : clock_ms;
            send_item(op, key, now, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        cache_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_queue.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer, tdata %h", m_tdata));
            end else begin
                want = result_queue.pop_front();
                if (m_tdata[0] !== want.hit)
                    note_mismatch($sformatf("hit %b, want %b", m_tdata[0], want.hit));
                if (m_tdata[2:1] !== want.act)
                    note_mismatch($sformatf("action %0d, want %s", m_tdata[2:1], want.act.name()));
                if (m_tdata[10:3] !== want.slot)
                    note_mismatch($sformatf("slot %0d, want %0d", m_tdata[10:3], want.slot));
                if (m_tdata[M_TDATA_W-1:11] !== {M_PAD_W{1'b0}})
                    note_mismatch($sformatf("pad bits %b", m_tdata[M_TDATA_W-1:11]));
            end
            results_seen++;
        end
    end

    initial begin
        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_expiry[i] = '0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_TTL)
                set_ttl(directed_rows[n].value);
            else
                send_item(directed_rows[n].op, directed_rows[n].key, directed_rows[n].value,
                          directed_rows[n].kind == ROW_PINNED,
                          {directed_rows[n].hit, directed_rows[n].act, directed_rows[n].slot});
        end

        clock_ms = 32'd1_000_000;
        run_phase(TTL_RESET,          200, 50, 30,  40, 20000,   3);
        run_phase(32'd1,              100, 50, 20,  16, 2,       0);
        // enough fresh keys to fill the store and force replacements
        run_phase(32'd1_000_000_000,  400, 85, 90, 320, 50,      0);
        run_phase(32'hFFFF_FFFF,      150, 50, 20,  24, 0,      60);
        run_phase($urandom,           240, 55, 25,  64, 1000000, 5);
        run_phase(32'd0,               60, 50, 30,   8, 100,     0);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (result_queue.size() != 0) @(negedge aclk);
        repeat (2 * ENTRIES + 8) @(negedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("timeout with %0d results outstanding", result_queue.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tac_pkg.sv
rtl/core/tac_ram.sv
rtl/core/ttl_address_cache_core.sv
bench/tb_ttl_address_cache_core.sv
